/* rtl/idm_pkg.sv */
// Shared types and constants for the 64-bit signed/unsigned integer divider.
package idm_pkg;

  localparam int FIELD_W        = 64;
  localparam int DATA_WIDTH_DEF = 64;

  typedef enum logic [1:0] {
    OP_UQUO = 2'd0,
    OP_UREM = 2'd1,
    OP_SQUO = 2'd2,
    OP_SREM = 2'd3
  } idm_op_t;

  // Control bits that travel alongside the operands through every stage.
  typedef struct packed {
    logic is_rem;
    logic neg_res;
    logic dz;
  } idm_ctrl_t;

endpackage

/* rtl/idm_req_if.sv */
// Request channel interface: operation code, dividend and divisor.
interface idm_req_if;
  import idm_pkg::*;

  logic                 valid;
  logic                 ready;
  idm_op_t              req_type;
  logic [FIELD_W-1:0]   dividend;
  logic [FIELD_W-1:0]   divisor;

  modport source (output valid, req_type, dividend, divisor, input ready);
  modport sink   (input valid, req_type, dividend, divisor, output ready);
endinterface

/* rtl/idm_rsp_if.sv */
// Result channel interface: answer and divide-by-zero flag.
interface idm_rsp_if;
  import idm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FIELD_W-1:0]   answer;
  logic                 divide_by_zero;

  modport source (output valid, answer, divide_by_zero, input ready);
  modport sink   (input valid, answer, divide_by_zero, output ready);
endinterface

/* rtl/idm_prep.sv */
// Input stage: decodes the operation, takes operand magnitudes and detects a zero divisor.
module idm_prep #(
  parameter int W = idm_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  idm_pkg::idm_op_t    req_type,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor,
  output logic                valid_r,
  output idm_pkg::idm_ctrl_t  ctrl_r,
  output logic [W-1:0]        quo_r,
  output logic [W-1:0]        den_r
);
  import idm_pkg::*;

  logic         is_rem;
  logic         is_signed;
  logic         nneg;
  logic         dneg;
  logic         dz;
  idm_ctrl_t    ctrl_nxt;
  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;

  always_comb begin
    unique case (req_type) inside
      OP_UQUO: begin is_rem = 1'b0; is_signed = 1'b0; end
      OP_UREM: begin is_rem = 1'b1; is_signed = 1'b0; end
      OP_SQUO: begin is_rem = 1'b0; is_signed = 1'b1; end
      OP_SREM: begin is_rem = 1'b1; is_signed = 1'b1; end
      default: begin is_rem = 1'b0; is_signed = 1'b0; end
    endcase
  end

  assign nneg    = is_signed & dividend[W-1];
  assign dneg    = is_signed & divisor[W-1];
  assign dz      = (divisor == {W{1'b0}});
  assign num_mag = nneg ? ({W{1'b0}} - dividend) : dividend;
  assign den_mag = dneg ? ({W{1'b0}} - divisor) : divisor;

  // A zero divisor yields an all-ones quotient, so the quotient is never negated then.
  // The remainder path returns the magnitude, and negating it restores the dividend.
  always_comb begin
    ctrl_nxt.is_rem  = is_rem;
    ctrl_nxt.dz      = dz;
    ctrl_nxt.neg_res = is_rem ? nneg : ((nneg ^ dneg) & ~dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r <= ctrl_nxt;
      quo_r  <= num_mag;
      den_r  <= den_mag;
    end
  end

endmodule

/* rtl/idm_step.sv */
// One restoring division step: produces one quotient bit per pipeline stage.
module idm_step #(
  parameter int W = idm_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                valid_i,
  input  idm_pkg::idm_ctrl_t  ctrl_i,
  input  logic [W-1:0]        rem_i,
  input  logic [W-1:0]        quo_i,
  input  logic [W-1:0]        den_i,
  output logic                valid_r,
  output idm_pkg::idm_ctrl_t  ctrl_r,
  output logic [W-1:0]        rem_r,
  output logic [W-1:0]        quo_r,
  output logic [W-1:0]        den_r
);
  import idm_pkg::*;

  logic [W:0]   rem_shift;
  logic [W:0]   diff;
  logic         q_bit;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;

  // The dividend bits leave the top of quo while quotient bits enter at the bottom.
  assign rem_shift = {rem_i, quo_i[W-1]};
  assign diff      = rem_shift - {1'b0, den_i};
  assign q_bit     = ~diff[W];
  assign rem_nxt   = q_bit ? diff[W-1:0] : rem_shift[W-1:0];
  assign quo_nxt   = {quo_i[W-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r <= ctrl_i;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_i;
    end
  end

endmodule

/* rtl/idm_post.sv */
// Output stage: selects quotient or remainder, applies the sign and holds the result.
module idm_post #(
  parameter int W = idm_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                valid_i,
  input  idm_pkg::idm_ctrl_t  ctrl_i,
  input  logic [W-1:0]        rem_i,
  input  logic [W-1:0]        quo_i,
  output logic                valid_r,
  output logic [W-1:0]        answer_r,
  output logic                dz_r
);
  import idm_pkg::*;

  logic [W-1:0] sel;
  logic [W-1:0] answer_nxt;

  assign sel        = ctrl_i.is_rem ? rem_i : quo_i;
  assign answer_nxt = ctrl_i.neg_res ? ({W{1'b0}} - sel) : sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      answer_r <= answer_nxt;
      dz_r     <= ctrl_i.dz;
    end
  end

endmodule

/* rtl/int64_divide_modulo_top.sv */
// Top level of the pipelined signed/unsigned integer divider.
//
//   Channel   Dir   Handshake          Payload
//   in_req    in    valid / ready      req_type, dividend, divisor
//   out_rsp   out   valid / ready      answer, divide_by_zero
//
// One request enters per cycle while the output is not stalled. With W = DATA_WIDTH capped at 64,
// the pipeline holds W + 2 stages: an operand preparation stage, one restoring-division stage per
// quotient bit, and an output stage. A result passes through these stages in that order and
// waits in the output stage until out_rsp.ready is high.
// Reset clears only the stage valid bits; operand registers are loaded as requests pass.
// When a result waits and out_rsp.ready is low, every stage holds its contents.
module int64_divide_modulo_top #(
  parameter int DATA_WIDTH = idm_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  idm_req_if.sink     in_req,
  idm_rsp_if.source   out_rsp
);
  import idm_pkg::*;

  localparam int OpW = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;

  logic           adv;
  logic           st_valid [0:OpW];
  idm_ctrl_t      st_ctrl  [0:OpW];
  logic [OpW-1:0] st_quo   [0:OpW];
  logic [OpW-1:0] st_den   [0:OpW];
  logic [OpW-1:0] st_rem   [1:OpW];
  logic           post_valid;
  logic [OpW-1:0] post_answer;
  logic           post_dz;

  // The whole pipeline moves together unless a finished result is being held.
  assign adv          = ~post_valid | out_rsp.ready;
  assign in_req.ready = adv;

  idm_prep #(.W(OpW)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_req.valid),
    .req_type (in_req.req_type),
    .dividend (in_req.dividend[OpW-1:0]),
    .divisor  (in_req.divisor[OpW-1:0]),
    .valid_r  (st_valid[0]),
    .ctrl_r   (st_ctrl[0]),
    .quo_r    (st_quo[0]),
    .den_r    (st_den[0])
  );

  for (genvar i = 0; i < OpW; i++) begin : g_step
    logic [OpW-1:0] rem_in;

    if (i == 0) begin : g_first
      assign rem_in = {OpW{1'b0}};
    end else begin : g_next
      assign rem_in = st_rem[i];
    end

    idm_step #(.W(OpW)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (st_valid[i]),
      .ctrl_i  (st_ctrl[i]),
      .rem_i   (rem_in),
      .quo_i   (st_quo[i]),
      .den_i   (st_den[i]),
      .valid_r (st_valid[i+1]),
      .ctrl_r  (st_ctrl[i+1]),
      .rem_r   (st_rem[i+1]),
      .quo_r   (st_quo[i+1]),
      .den_r   (st_den[i+1])
    );
  end

  idm_post #(.W(OpW)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .valid_i  (st_valid[OpW]),
    .ctrl_i   (st_ctrl[OpW]),
    .rem_i    (st_rem[OpW]),
    .quo_i    (st_quo[OpW]),
    .valid_r  (post_valid),
    .answer_r (post_answer),
    .dz_r     (post_dz)
  );

  assign out_rsp.valid          = post_valid;
  assign out_rsp.answer         = FIELD_W'(post_answer);
  assign out_rsp.divide_by_zero = post_dz;

`ifndef SYNTHESIS
  // A completed division with a nonzero divisor always leaves a remainder below the divisor magnitude.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid[OpW] && !st_ctrl[OpW].dz |-> (st_rem[OpW] < st_den[OpW]))
    else $error("final remainder is not below the divisor");

  // With a zero divisor every step must have produced a one in the quotient.
  a_dz_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid[OpW] && st_ctrl[OpW].dz && !st_ctrl[OpW].is_rem |-> (&st_quo[OpW]))
    else $error("zero divisor did not give an all-ones quotient");

  // A stall must freeze the last division stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && st_valid[OpW] |=> st_valid[OpW] && $stable(st_quo[OpW])
                               && $stable(st_rem[OpW]))
    else $error("last division stage changed during a stall");
`endif

endmodule
